### sv/arsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arsp_pkg
// Types and constants shared by the activity record stream parser.
// ----------------------------------------------------------------------------
package arsp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } arsp_in_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [1:0]  detail_code;
    logic [7:0]  activity;
    logic [31:0] latitude;
    logic [31:0] longitude;
    logic [15:0] speed;
    logic [31:0] timestamp;
    logic [7:0]  hr_bpm;
    logic [7:0]  record_tag;
  } arsp_out_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic     valid;
    arsp_in_t item;
  } arsp_qhead_t;

  typedef enum logic [4:0] {
    PH_HDR, PH_VER, PH_WATCH, PH_TS1, PH_FILL, PH_TS2, PH_PAD, PH_COUNT,
    PH_DTAG, PH_DLEN, PH_REC, PH_SEG, PH_GPS, PH_HR, PH_LAP, PH_SKIP, PH_IDLE
  } arsp_phase_t;

  localparam logic [2:0] EV_START = 3'd0;
  localparam logic [2:0] EV_END   = 3'd1;
  localparam logic [2:0] EV_GPS   = 3'd2;
  localparam logic [2:0] EV_HR    = 3'd3;
  localparam logic [2:0] EV_WARN  = 3'd4;
  localparam logic [2:0] EV_FATAL = 3'd5;

  localparam logic [1:0] WARN_TS_MISMATCH = 2'd0;
  localparam logic [1:0] WARN_BAD_IND     = 2'd1;
  localparam logic [1:0] WARN_HR_NO_GPS   = 2'd2;
  localparam logic [1:0] WARN_UNKNOWN_TAG = 2'd3;
  localparam logic [1:0] FATAL_BAD_TAG    = 2'd0;
  localparam logic [1:0] FATAL_BAD_VER    = 2'd1;
  localparam logic [1:0] FATAL_GPS_NO_SEG = 2'd2;
  localparam logic [1:0] FATAL_TRUNC      = 2'd3;

  localparam logic [7:0] TAG_HEADER  = 8'h20;
  localparam logic [7:0] TAG_SEGMENT = 8'h21;
  localparam logic [7:0] TAG_GPS     = 8'h22;
  localparam logic [7:0] TAG_HR      = 8'h25;
  localparam logic [7:0] TAG_LAP     = 8'h2f;
  localparam logic [7:0] FILL_ZERO   = 8'h00;
  localparam logic [7:0] FILL_DASH   = 8'h2d;

  localparam logic [7:0] IND_NONE  = 8'd0;
  localparam logic [7:0] IND_START = 8'd1;
  localparam logic [7:0] IND_END   = 8'd2;
  localparam logic [7:0] IND_WORK  = 8'd3;

  localparam logic [31:0] NO_FIX_STAMP    = 32'hffffffff;
  localparam logic [7:0]  VERSION_DEFAULT = 8'd7;

endpackage
`default_nettype wire

### sv/arsp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arsp_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module arsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### sv/arsp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arsp_front
// Input side: takes stream bytes into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module arsp_front
  import arsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire arsp_in_t    in_data,
  output logic             in_stall,
  output arsp_qhead_t      head,
  input  wire logic        pop
);

  arsp_in_t   q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_stall   = (cnt_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_data;
    end
  end

endmodule
`default_nettype wire

### sv/arsp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arsp_back
// Parser back end: dictionary lookup stage, record state machine and
// output register.
// ----------------------------------------------------------------------------
module arsp_back
  import arsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  version,
  input  wire arsp_qhead_t head,
  output logic             pop,
  output logic             out_valid,
  output arsp_out_t        out_data,
  input  wire logic        out_stall
);

  arsp_phase_t phase_r, phase_nxt, phase_step;
  logic [4:0]   pos_r, pos_nxt, pos_inc;
  logic [7:0]   tag_r, tag_nxt, tag_step;
  logic [31:0]  fs_r, fs_nxt;
  logic [31:0]  lat_r, lat_nxt, lon_r, lon_nxt, fst_r, fst_nxt;
  logic [15:0]  spd_r, spd_nxt, sh_r, sh_nxt, skip_r, skip_nxt;
  logic [7:0]   ent_r, ent_nxt;
  logic [255:0] lv_r, lv_nxt;
  logic         inseg_r, inseg_nxt, hp_r, hp_nxt;

  logic         sb_v_r;
  arsp_in_t     sb_r;
  logic         byp_r;
  logic [15:0]  bypd_r;
  logic         out_v_r;
  arsp_out_t    out_r;

  logic         adv, proc;
  logic [7:0]   b;
  logic [15:0]  ram_q, len;
  logic         ram_we;
  logic [15:0]  ram_wd;
  arsp_out_t    ev;
  logic         ev_v;

  assign adv  = !out_v_r || !out_stall;
  assign proc = sb_v_r && adv;
  assign pop  = head.valid && (!sb_v_r || adv);
  assign b    = sb_r.data_byte;
  assign len  = byp_r ? bypd_r : ram_q;
  assign pos_inc = pos_r + 5'd1;
  assign fs_nxt  = {b, fs_r[31:8]};

  assign ram_we = proc && (phase_r == PH_DLEN) && (pos_inc >= 5'd2);
  assign ram_wd = fs_nxt[31:16] - 16'd1;

  arsp_ram #(.WIDTH(16), .DEPTH(256)) u_len (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tag_r),
    .wdata (ram_wd),
    .re    (pop),
    .raddr (head.item.data_byte),
    .rdata (ram_q)
  );

  // next state and datapath
  always_comb begin
    phase_step = phase_r;
    pos_nxt    = pos_r;
    tag_step   = tag_r;
    lat_nxt    = lat_r;
    lon_nxt    = lon_r;
    spd_nxt    = spd_r;
    sh_nxt     = sh_r;
    fst_nxt    = fst_r;
    ent_nxt    = ent_r;
    skip_nxt   = skip_r;
    lv_nxt     = lv_r;
    inseg_nxt  = inseg_r;
    hp_nxt     = hp_r;
    unique case (phase_r)
      PH_HDR: begin
        if (b == TAG_HEADER) begin
          tag_step   = TAG_HEADER;
          phase_step = PH_VER;
        end else begin
          phase_step = PH_IDLE;
        end
      end
      PH_VER: begin
        if (b != version) begin
          phase_step = PH_IDLE;
        end else begin
          phase_step = PH_WATCH;
          pos_nxt    = 5'd0;
        end
      end
      PH_WATCH: begin
        pos_nxt = pos_inc;
        if (pos_inc >= 5'd6) begin
          phase_step = PH_TS1;
          pos_nxt    = 5'd0;
        end
      end
      PH_TS1: begin
        pos_nxt = pos_inc;
        if (pos_inc >= 5'd4) begin
          fst_nxt    = fs_nxt;
          phase_step = PH_FILL;
        end
      end
      PH_FILL: begin
        if (b != FILL_ZERO && b != FILL_DASH) begin
          phase_step = PH_TS2;
          pos_nxt    = 5'd1;
        end
      end
      PH_TS2: begin
        pos_nxt = pos_inc;
        if (pos_inc >= 5'd4) begin
          phase_step = PH_PAD;
          pos_nxt    = 5'd0;
        end
      end
      PH_PAD: begin
        pos_nxt = pos_inc;
        if (pos_inc >= 5'd5) begin
          phase_step = PH_COUNT;
        end
      end
      PH_COUNT: begin
        ent_nxt    = b;
        phase_step = (b != 8'd0) ? PH_DTAG : PH_REC;
      end
      PH_DTAG: begin
        tag_step   = b;
        pos_nxt    = 5'd0;
        phase_step = PH_DLEN;
      end
      PH_DLEN: begin
        pos_nxt = pos_inc;
        if (pos_inc >= 5'd2) begin
          lv_nxt[tag_r] = 1'b1;
          ent_nxt       = ent_r - 8'd1;
          phase_step    = (ent_r != 8'd1) ? PH_DTAG : PH_REC;
          tag_step      = TAG_HEADER;
        end
      end
      PH_REC: begin
        tag_step = b;
        pos_nxt  = 5'd0;
        priority if (b == TAG_SEGMENT) begin
          phase_step = PH_SEG;
        end else if (b == TAG_GPS) begin
          phase_step = inseg_r ? PH_GPS : PH_IDLE;
        end else if (b == TAG_HR) begin
          phase_step = PH_HR;
        end else if (b == TAG_LAP) begin
          phase_step = PH_LAP;
        end else if (lv_r[b]) begin
          skip_nxt   = len;
          phase_step = (len != 16'd0) ? PH_SKIP : PH_REC;
        end else begin
          // unknown tag: drop it and read the next byte as a tag
          phase_step = PH_REC;
        end
      end
      PH_SEG: begin
        if (pos_r == 5'd0) begin
          sh_nxt = {8'd0, b};
        end else if (pos_r == 5'd1) begin
          sh_nxt = {b, sh_r[7:0]};
        end
        pos_nxt = pos_inc;
        if (pos_inc >= 5'd6) begin
          phase_step = PH_REC;
          if (sh_r[7:0] == IND_START) begin
            inseg_nxt = 1'b1;
            hp_nxt    = 1'b0;
          end else if (sh_r[7:0] == IND_END) begin
            inseg_nxt = 1'b0;
            hp_nxt    = 1'b0;
          end
        end
      end
      PH_GPS: begin
        pos_nxt = pos_inc;
        if (pos_inc == 5'd4) begin
          lat_nxt = fs_nxt;
        end else if (pos_inc == 5'd8) begin
          lon_nxt = fs_nxt;
        end else if (pos_inc == 5'd12) begin
          spd_nxt = fs_nxt[31:16];
        end else if (pos_inc == 5'd16) begin
          fst_nxt = fs_nxt;
        end else if (pos_inc >= 5'd27) begin
          if (fst_r != NO_FIX_STAMP) begin
            hp_nxt = 1'b1;
          end
          phase_step = PH_REC;
        end
      end
      PH_HR: begin
        if (pos_r == 5'd0) begin
          sh_nxt = {8'd0, b};
        end
        pos_nxt = pos_inc;
        if (pos_inc >= 5'd6) begin
          phase_step = PH_REC;
        end
      end
      PH_LAP: begin
        pos_nxt = pos_inc;
        if (pos_inc >= 5'd10) begin
          phase_step = PH_REC;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_r == 16'd1) begin
          phase_step = PH_REC;
        end
      end
      default: begin
        phase_step = PH_IDLE;
      end
    endcase
    phase_nxt = phase_step;
    tag_nxt   = tag_step;
    // rearm at the end of every file
    if (sb_r.last_byte) begin
      phase_nxt = PH_HDR;
      pos_nxt   = 5'd0;
      inseg_nxt = 1'b0;
      hp_nxt    = 1'b0;
    end
  end

  // result of the byte in the lookup stage
  always_comb begin
    ev   = '0;
    ev_v = 1'b0;
    unique case (phase_r)
      PH_HDR: begin
        if (b != TAG_HEADER) begin
          ev_v = 1'b1;
          ev.event_kind  = EV_FATAL;
          ev.detail_code = FATAL_BAD_TAG;
          ev.record_tag  = b;
        end
      end
      PH_VER: begin
        if (b != version) begin
          ev_v = 1'b1;
          ev.event_kind  = EV_FATAL;
          ev.detail_code = FATAL_BAD_VER;
          ev.record_tag  = TAG_HEADER;
        end
      end
      PH_TS2: begin
        if (pos_inc >= 5'd4 && fs_nxt != fst_r) begin
          ev_v = 1'b1;
          ev.event_kind  = EV_WARN;
          ev.detail_code = WARN_TS_MISMATCH;
          ev.record_tag  = TAG_HEADER;
          ev.timestamp   = fs_nxt;
        end
      end
      PH_REC: begin
        if (b == TAG_GPS && !inseg_r) begin
          ev_v = 1'b1;
          ev.event_kind  = EV_FATAL;
          ev.detail_code = FATAL_GPS_NO_SEG;
          ev.record_tag  = b;
        end else if (b != TAG_SEGMENT && b != TAG_GPS && b != TAG_HR &&
                     b != TAG_LAP && !lv_r[b]) begin
          ev_v = 1'b1;
          ev.event_kind  = EV_WARN;
          ev.detail_code = WARN_UNKNOWN_TAG;
          ev.record_tag  = b;
        end
      end
      PH_SEG: begin
        if (pos_inc >= 5'd6) begin
          if (sh_r[7:0] == IND_START) begin
            ev_v = 1'b1;
            ev.event_kind = EV_START;
            ev.activity   = sh_r[15:8];
            ev.timestamp  = fs_nxt;
          end else if (sh_r[7:0] == IND_END) begin
            ev_v = 1'b1;
            ev.event_kind = EV_END;
            ev.timestamp  = fs_nxt;
          end else if (sh_r[7:0] != IND_NONE && sh_r[7:0] != IND_WORK) begin
            ev_v = 1'b1;
            ev.event_kind  = EV_WARN;
            ev.detail_code = WARN_BAD_IND;
            ev.record_tag  = TAG_SEGMENT;
          end
        end
      end
      PH_GPS: begin
        if (pos_inc >= 5'd27 && fst_r != NO_FIX_STAMP) begin
          ev_v = 1'b1;
          ev.event_kind = EV_GPS;
          ev.latitude   = lat_r;
          ev.longitude  = lon_r;
          ev.speed      = spd_r;
          ev.timestamp  = fst_r;
        end
      end
      PH_HR: begin
        if (pos_inc >= 5'd6) begin
          ev_v = 1'b1;
          if (hp_r) begin
            ev.event_kind = EV_HR;
            ev.timestamp  = fs_nxt;
            ev.hr_bpm     = sh_r[7:0];
          end else begin
            ev.event_kind  = EV_WARN;
            ev.detail_code = WARN_HR_NO_GPS;
            ev.record_tag  = TAG_HR;
          end
        end
      end
      default: begin
        ev_v = 1'b0;
      end
    endcase
    // truncation replaces anything else on the last byte
    if (sb_r.last_byte && phase_step != PH_REC && phase_step != PH_IDLE) begin
      ev   = '0;
      ev_v = 1'b1;
      ev.event_kind  = EV_FATAL;
      ev.detail_code = FATAL_TRUNC;
      ev.record_tag  = tag_step;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      pos_r   <= 5'd0;
      tag_r   <= 8'd0;
      fs_r    <= 32'd0;
      lat_r   <= 32'd0;
      lon_r   <= 32'd0;
      spd_r   <= 16'd0;
      sh_r    <= 16'd0;
      fst_r   <= 32'd0;
      ent_r   <= 8'd0;
      skip_r  <= 16'd0;
      lv_r    <= '0;
      inseg_r <= 1'b0;
      hp_r    <= 1'b0;
      sb_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (proc) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        tag_r   <= tag_nxt;
        fs_r    <= fs_nxt;
        lat_r   <= lat_nxt;
        lon_r   <= lon_nxt;
        spd_r   <= spd_nxt;
        sh_r    <= sh_nxt;
        fst_r   <= fst_nxt;
        ent_r   <= ent_nxt;
        skip_r  <= skip_nxt;
        lv_r    <= lv_nxt;
        inseg_r <= inseg_nxt;
        hp_r    <= hp_nxt;
      end
      if (pop) begin
        sb_v_r <= 1'b1;
      end else if (proc) begin
        sb_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= proc && ev_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sb_r <= head.item;
      // forward a dictionary write that lands on the entry being read
      byp_r  <= ram_we && (tag_r == head.item.data_byte);
      bypd_r <= ram_wd;
    end
    if (adv && proc && ev_v) begin
      out_r <= ev;
    end
  end

endmodule
`default_nettype wire

### sv/activity_record_stream_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// activity_record_stream_parser_unit
// Byte-serial parser for activity-log files: header, length dictionary and
// segment, gps, heart-rate and lap records.
//
//   channel   dir   handshake              payload
//   in_       in    in_valid / in_stall    arsp_in_t  (data_byte, last_byte)
//   out_      out   out_valid / out_stall  arsp_out_t (one event per byte, max)
//   cfg_      in    cfg_wr_en              cfg_wr_data = expected_version
//
// One byte per cycle sustained while the output is not stalled. A byte passes
// the two-entry input queue, then the dictionary lookup stage (registered RAM
// read), then the output register. Reset is synchronous, active low; the
// dictionary valid bits clear at once. A held output stalls the parser stage,
// and the queue absorbs the two bytes behind it.
// ----------------------------------------------------------------------------
module activity_record_stream_parser_unit
  import arsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire arsp_in_t   in_data,
  output logic            in_stall,
  output logic            out_valid,
  output arsp_out_t       out_data,
  input  wire logic       out_stall,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);

  logic [7:0]  version_r;
  arsp_qhead_t head;
  logic        pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= VERSION_DEFAULT;
    end else if (cfg_wr_en) begin
      version_r <= cfg_wr_data;
    end
  end

  arsp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .head     (head),
    .pop      (pop)
  );

  arsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .version   (version_r),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
`default_nettype wire

### dv/tb_activity_record_stream_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_activity_record_stream_parser_unit
// Self-checking bench for the activity record stream parser. It sends
// byte-serial activity-log files and predicts every event in a local
// byte-level model. Each result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_activity_record_stream_parser_unit;
  import arsp_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  arsp_in_t   in_data;
  logic       in_stall;
  logic       out_valid;
  arsp_out_t  out_data;
  logic       out_stall;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  activity_record_stream_parser_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  // parser copy
  logic [7:0]  want_version;
  arsp_phase_t phase;
  logic [4:0]  pos;
  logic [7:0]  cur_tag;
  logic [31:0] shreg;
  logic [31:0] lat_q, lon_q, first_ts;
  logic [15:0] speed_q, small_q, skip_cnt;
  logic [7:0]  dict_left;
  logic        len_known [256];
  logic [15:0] len_minus1 [256];
  logic        seg_open, point_seen;

  arsp_out_t event_queue[$];
  int errors, events_seen, bytes_sent, cycles;
  logic hold_long;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("activity_record_stream_parser_unit regression: fail");
      $finish;
    end
  end

  function automatic arsp_out_t make_event(logic [2:0] k, logic [1:0] d, logic [7:0] t);
    arsp_out_t e;
    e = '0;
    e.event_kind = k;
    e.detail_code = d;
    e.record_tag = t;
    return e;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic last);
    arsp_out_t e;
    logic      hit;
    hit = 1'b0;
    e = '0;
    shreg = {b, shreg[31:8]};
    case (phase)
      PH_HDR: begin
        if (b == TAG_HEADER) begin
          cur_tag = TAG_HEADER;
          phase = PH_VER;
        end else begin
          e = make_event(EV_FATAL, FATAL_BAD_TAG, b); hit = 1'b1;
          phase = PH_IDLE;
        end
      end
      PH_VER: begin
        if (b != want_version) begin
          e = make_event(EV_FATAL, FATAL_BAD_VER, TAG_HEADER); hit = 1'b1;
          phase = PH_IDLE;
        end else begin
          phase = PH_WATCH; pos = 0;
        end
      end
      PH_WATCH: begin
        pos++;
        if (pos >= 6) begin phase = PH_TS1; pos = 0; end
      end
      PH_TS1: begin
        pos++;
        if (pos >= 4) begin first_ts = shreg; phase = PH_FILL; end
      end
      PH_FILL: if (b != FILL_ZERO && b != FILL_DASH) begin phase = PH_TS2; pos = 1; end
      PH_TS2: begin
        pos++;
        if (pos >= 4) begin
          if (shreg != first_ts) begin
            e = make_event(EV_WARN, WARN_TS_MISMATCH, TAG_HEADER);
            e.timestamp = shreg; hit = 1'b1;
          end
          phase = PH_PAD; pos = 0;
        end
      end
      PH_PAD: begin
        pos++;
        if (pos >= 5) phase = PH_COUNT;
      end
      PH_COUNT: begin
        dict_left = b;
        phase = (b != 0) ? PH_DTAG : PH_REC;
      end
      PH_DTAG: begin cur_tag = b; pos = 0; phase = PH_DLEN; end
      PH_DLEN: begin
        pos++;
        if (pos >= 2) begin
          len_minus1[cur_tag] = shreg[31:16] - 16'd1;
          len_known[cur_tag] = 1'b1;
          dict_left--;
          phase = (dict_left != 0) ? PH_DTAG : PH_REC;
          cur_tag = TAG_HEADER;
        end
      end
      PH_REC: begin
        cur_tag = b; pos = 0;
        case (b)
          TAG_SEGMENT: phase = PH_SEG;
          TAG_GPS: begin
            if (!seg_open) begin
              e = make_event(EV_FATAL, FATAL_GPS_NO_SEG, b); hit = 1'b1;
              phase = PH_IDLE;
            end else phase = PH_GPS;
          end
          TAG_HR: phase = PH_HR;
          TAG_LAP: phase = PH_LAP;
          default: begin
            if (len_known[b]) begin
              skip_cnt = len_minus1[b];
              phase = (skip_cnt != 0) ? PH_SKIP : PH_REC;
            end else begin
              e = make_event(EV_WARN, WARN_UNKNOWN_TAG, b); hit = 1'b1;
            end
          end
        endcase
      end
      PH_SEG: begin
        if (pos == 0) small_q = {8'd0, b};
        else if (pos == 1) small_q[15:8] = b;
        pos++;
        if (pos >= 6) begin
          if (small_q[7:0] == IND_START) begin
            seg_open = 1'b1; point_seen = 1'b0;
            e = make_event(EV_START, 2'd0, 8'd0);
            e.activity = small_q[15:8]; e.timestamp = shreg; hit = 1'b1;
          end else if (small_q[7:0] == IND_END) begin
            seg_open = 1'b0; point_seen = 1'b0;
            e = make_event(EV_END, 2'd0, 8'd0);
            e.timestamp = shreg; hit = 1'b1;
          end else if (small_q[7:0] != IND_NONE && small_q[7:0] != IND_WORK) begin
            e = make_event(EV_WARN, WARN_BAD_IND, TAG_SEGMENT); hit = 1'b1;
          end
          phase = PH_REC;
        end
      end
      PH_GPS: begin
        pos++;
        if (pos == 4) lat_q = shreg;
        else if (pos == 8) lon_q = shreg;
        else if (pos == 12) speed_q = shreg[31:16];
        else if (pos == 16) first_ts = shreg;
        else if (pos >= 27) begin
          if (first_ts != NO_FIX_STAMP) begin
            point_seen = 1'b1;
            e = make_event(EV_GPS, 2'd0, 8'd0);
            e.latitude = lat_q; e.longitude = lon_q;
            e.speed = speed_q; e.timestamp = first_ts; hit = 1'b1;
          end
          phase = PH_REC;
        end
      end
      PH_HR: begin
        if (pos == 0) small_q = {8'd0, b};
        pos++;
        if (pos >= 6) begin
          if (point_seen) begin
            e = make_event(EV_HR, 2'd0, 8'd0);
            e.timestamp = shreg; e.hr_bpm = small_q[7:0];
          end else e = make_event(EV_WARN, WARN_HR_NO_GPS, TAG_HR);
          hit = 1'b1;
          phase = PH_REC;
        end
      end
      PH_LAP: begin
        pos++;
        if (pos >= 10) phase = PH_REC;
      end
      PH_SKIP: begin
        skip_cnt--;
        if (skip_cnt == 0) phase = PH_REC;
      end
      default: phase = PH_IDLE;
    endcase
    if (last) begin
      if (phase != PH_REC && phase != PH_IDLE) begin
        e = make_event(EV_FATAL, FATAL_TRUNC, cur_tag); hit = 1'b1;
      end
      phase = PH_HDR; pos = 0;
      seg_open = 1'b0; point_seen = 1'b0;
    end
    if (hit) event_queue.push_back(e);
  endtask

  // one request: random gap, then hold until accepted
  task automatic send_byte(input logic [7:0] b, input logic last = 1'b0);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, last_byte: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_u32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) send_byte(v[8*i +: 8]);
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (event_queue.size() != 0 && guard < 5000) begin
      @(posedge clk); guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_version(input logic [7:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    want_version = v;
  endtask

  // header: tag, version, watch id, stamps with filler, pad, dictionary
  task automatic send_header(input logic [31:0] ts1, input logic [31:0] ts2,
                             input int fills, input int n_dict);
    logic [7:0] t;
    send_byte(TAG_HEADER);
    send_byte(want_version);
    repeat (6) send_byte(8'($urandom));
    send_u32(ts1);
    repeat (fills) send_byte($urandom_range(0, 1) ? FILL_DASH : FILL_ZERO);
    // first ts2 byte must end the filler
    send_byte((ts2[7:0] == FILL_ZERO || ts2[7:0] == FILL_DASH) ? 8'h01 : ts2[7:0]);
    for (int i = 1; i < 4; i++) send_byte(ts2[8*i +: 8]);
    repeat (5) send_byte(8'($urandom));
    send_byte(n_dict[7:0]);
    for (int i = 0; i < n_dict; i++) begin
      t = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(8'h30, 8'h3f));
      send_byte(t);
      if ($urandom_range(0, 5) == 0) begin
        send_byte(8'($urandom_range(0, 1))); send_byte(8'h00);
      end else begin
        send_byte(8'($urandom_range(1, 6))); send_byte(8'h00);
      end
    end
  endtask

  task automatic send_segment(input logic [7:0] ind, input logic [7:0] act);
    send_byte(TAG_SEGMENT); send_byte(ind); send_byte(act); send_u32($urandom);
  endtask

  task automatic send_gps(input logic no_fix);
    send_byte(TAG_GPS);
    send_u32($urandom); send_u32($urandom); send_u32($urandom);
    send_u32(no_fix ? NO_FIX_STAMP : 32'($urandom));
    repeat (11) send_byte(8'($urandom));
  endtask

  // tag, rate, one spare byte, stamp
  task automatic send_hr();
    send_byte(TAG_HR); send_byte(8'($urandom)); send_byte(8'($urandom));
    send_u32($urandom);
  endtask

  task automatic send_lap();
    send_byte(TAG_LAP); repeat (10) send_byte(8'($urandom));
  endtask

  task automatic send_any_record();
    int r;
    logic [7:0] t;
    r = $urandom_range(0, 19);
    if (r < 4) send_segment($urandom_range(0, 9) < 7 ? 8'($urandom_range(1, 2)) :
                            8'($urandom), 8'($urandom));
    else if (r < 10) send_gps($urandom_range(0, 9) == 0);
    else if (r < 13) send_hr();
    else if (r < 15) send_lap();
    else begin
      t = 8'($urandom_range(8'h30, 8'h3f));
      send_byte(t);
      // a wrapped length would skip a huge run; send only a few bytes of it
      if (len_known[t])
        repeat ((len_minus1[t] > 16'd6) ? 6 : int'(len_minus1[t])) send_byte(8'($urandom));
    end
  endtask

  task automatic close_file();
    send_byte(TAG_LAP); repeat (9) send_byte(8'($urandom));
    send_byte(8'($urandom), 1'b1);
  endtask

  task automatic test_header_errors();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(TAG_HEADER);
    send_byte(8'hff, 1'b1);
    send_byte(TAG_HEADER, 1'b1);
    send_header(32'h0, 32'hffffffff, 2, 0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_records_directed();
    send_header(32'h1234_5678, 32'h1234_5678, 0, 2);
    send_hr();
    send_segment(IND_START, 8'h00);
    send_gps(1'b1);
    send_hr();
    send_gps(1'b0);
    send_hr();
    send_segment(IND_WORK, 8'h01);
    send_segment(IND_NONE, 8'hff);
    send_segment(8'hff, 8'h01);
    send_byte(8'hee);
    send_lap();
    send_segment(IND_END, 8'h01);
    send_byte(8'h41, 1'b1);
    send_header(32'h1, 32'h1, 1, 0);
    send_gps(1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_random_files(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 40)) send_byte(8'($urandom));
        send_byte(8'($urandom), 1'b1);
      end else begin
        send_header($urandom, $urandom_range(0, 1) ? 32'h0 : 32'($urandom),
                    $urandom_range(0, 3), $urandom_range(0, 4));
        send_segment(IND_START, 8'($urandom_range(0, 1)));
        repeat ($urandom_range(2, 12)) send_any_record();
        if ($urandom_range(0, 4) == 0) send_byte(8'($urandom), 1'b1);
        else close_file();
      end
    end
  endtask

  task automatic test_backpressure();
    hold_long = 1'b1;
    send_header(32'h5, 32'h5, 0, 0);
    send_segment(IND_START, 8'h01);
    repeat (4) send_gps(1'b0);
    hold_long = 1'b0;
    close_file();
    wait_idle();
  endtask

  // result side: random stalls, long hold-off on request
  initial begin
    int hold_cnt;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long && hold_cnt < 200) begin
        out_stall <= 1'b1; hold_cnt++;
      end else begin
        if (!hold_long) hold_cnt = 0;
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  always @(posedge clk) begin
    arsp_out_t exp_ev;
    if (rst_n && out_valid && !out_stall) begin
      events_seen++;
      if (event_queue.size() == 0) begin
        $display("%0t unexpected event: actual %h", $time, out_data);
        errors++;
      end else begin
        exp_ev = event_queue.pop_front();
        if (exp_ev !== out_data) begin
          $display("%0t event mismatch: expected %h actual %h", $time, exp_ev, out_data);
          errors++;
        end
      end
    end
  end

  initial begin
    errors = 0; events_seen = 0; bytes_sent = 0; cycles = 0;
    hold_long = 1'b0;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    cfg_wr_en = 1'b0; cfg_wr_data = '0;
    want_version = VERSION_DEFAULT;
    phase = PH_HDR; pos = '0; cur_tag = '0; shreg = '0;
    lat_q = '0; lon_q = '0; first_ts = '0; speed_q = '0; small_q = '0;
    skip_cnt = '0; dict_left = '0; seg_open = 1'b0; point_seen = 1'b0;
    for (int i = 0; i < 256; i++) begin len_known[i] = 1'b0; len_minus1[i] = '0; end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_header_errors();
    test_records_directed();
    test_backpressure();
    write_version(8'h00);
    test_random_files(300);
    write_version(8'hff);
    test_random_files(300);
    write_version(8'ha5);
    test_random_files(300);
    write_version(VERSION_DEFAULT);
    test_random_files(300);
    wait_idle();

    $display("sent %0d bytes over many files and four version settings, %0d events checked",
             bytes_sent, events_seen);
    if (errors == 0 && event_queue.size() == 0) begin
      $display("activity_record_stream_parser_unit regression: pass");
    end else begin
      $display("%0d mismatches, %0d events missing", errors, event_queue.size());
      $display("activity_record_stream_parser_unit regression: fail");
    end
    $finish;
  end
endmodule

### activity_record_stream_parser_unit.f
sv/arsp_pkg.sv
sv/arsp_ram.sv
sv/arsp_front.sv
sv/arsp_back.sv
sv/activity_record_stream_parser_unit.sv
dv/tb_activity_record_stream_parser_unit.sv
